// File: hdl/ralu_pkg.sv
// Package for the A64 register-form ALU execute block.
// Shared constants, item kinds and the decoded item type. No dependencies.
package ralu_pkg;

    localparam int XLEN      = 64;
    localparam int NUM_GPR   = 31;
    localparam int REG_IDX_W = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [REG_IDX_W-1:0] ZERO_REG = 5'd31;

    localparam logic [2:0] KIND_LOAD  = 3'd0;
    localparam logic [2:0] KIND_ILL   = 3'd1;
    localparam logic [2:0] KIND_MUL   = 3'd2;
    localparam logic [2:0] KIND_ARITH = 3'd3;
    localparam logic [2:0] KIND_LOGIC = 3'd4;

    localparam logic [2:0] MAJOR_DP_REG = 3'b101;
    localparam logic [3:0] MUL_OP31     = 4'b1000;

    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ASR = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    localparam logic [1:0] LOGIC_AND  = 2'd0;
    localparam logic [1:0] LOGIC_ORR  = 2'd1;
    localparam logic [1:0] LOGIC_EOR  = 2'd2;
    localparam logic [1:0] LOGIC_ANDS = 2'd3;

    localparam logic [1:0] MUL_STEP_LL  = 2'd0;
    localparam logic [1:0] MUL_STEP_LH  = 2'd1;
    localparam logic [1:0] MUL_STEP_HL  = 2'd2;
    localparam logic [1:0] MUL_STEP_SUM = 2'd3;

    typedef struct packed {
        logic [2:0]           kind;
        logic                 sf;
        logic [1:0]           opc;
        logic [1:0]           stype;
        logic                 neg;
        logic [5:0]           amt;
        logic [REG_IDX_W-1:0] rn;
        logic [REG_IDX_W-1:0] rm;
        logic [REG_IDX_W-1:0] ra;
        logic [REG_IDX_W-1:0] rd;
        logic                 mul_sub;
        logic [XLEN-1:0]      load_value;
    } decoded_t;

endpackage

// File: hdl/ralu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ralu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en && (32'(wr_addr) < DEPTH)) begin
            mem[wr_addr] <= wr_data;
        end
        if (32'(rd_addr) < DEPTH) begin
            rd_data_reg <= mem[rd_addr];
        end else begin
            rd_data_reg <= '0;
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: hdl/ralu_front.sv
// Front end: accepts input transfers and decodes them into queue entries.
// Depends on ralu_pkg.
module ralu_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [103:0]         s_tdata,
    input  logic                 s_tuser,
    input  logic                 queue_full,
    output logic                 push,
    output ralu_pkg::decoded_t   push_entry
);
    import ralu_pkg::*;

    logic [31:0] w;
    logic        is_mul, addsub_sel;

    assign w          = s_tdata[31:0];
    assign is_mul     = w[28];
    assign addsub_sel = w[24];
    assign s_tready   = !queue_full;
    assign push       = s_tvalid && !queue_full;

    always_comb begin
        push_entry            = '0;
        push_entry.sf         = w[31];
        push_entry.opc        = w[30:29];
        push_entry.stype      = w[23:22];
        push_entry.neg        = w[21];
        push_entry.amt        = w[15:10];
        push_entry.rn         = w[9:5];
        push_entry.rm         = w[20:16];
        push_entry.ra         = w[14:10];
        push_entry.rd         = w[4:0];
        push_entry.mul_sub    = w[15];
        push_entry.load_value = s_tdata[100:37];
        if (s_tuser) begin
            push_entry.kind = KIND_LOAD;
            push_entry.rd   = s_tdata[36:32];
        end else if (w[27:25] != MAJOR_DP_REG) begin
            push_entry.kind = KIND_ILL;
        end else if (is_mul) begin
            push_entry.kind = (w[24:21] != MUL_OP31) ? KIND_ILL : KIND_MUL;
        end else if (!w[31] && w[15]) begin
            push_entry.kind = KIND_ILL;
        end else if (addsub_sel && (w[21] || (w[23:22] == SHIFT_ROR && w[15:10] != 6'd0))) begin
            push_entry.kind = KIND_ILL;
        end else begin
            push_entry.kind = addsub_sel ? KIND_ARITH : KIND_LOGIC;
        end
    end
endmodule

// File: hdl/ralu_queue.sv
// Short queue of decoded items between front and back end.
// Depends on ralu_pkg.
module ralu_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ralu_pkg::decoded_t push_entry,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output ralu_pkg::decoded_t head
);
    import ralu_pkg::*;

    decoded_t entries_reg [QUEUE_DEPTH];
    logic [$clog2(QUEUE_DEPTH)-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] count_reg, count_next;
    logic do_pop;

    assign full      = (32'(count_reg) == QUEUE_DEPTH);
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end
endmodule

// File: hdl/ralu_back.sv
// Back end: register file, shifter, adder, iterative multiplier, flags and
// output register. Depends on ralu_pkg and ralu_ram.
module ralu_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  ralu_pkg::decoded_t q_head,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [79:0]        m_tdata
);
    import ralu_pkg::*;

    decoded_t e_reg, e_next, rd_sel;
    logic     e_valid_reg, e_valid_next;
    logic [1:0] mul_cnt_reg, mul_cnt_next;
    logic [63:0] p0_reg;
    logic [31:0] p1_reg, p2_reg;

    logic [XLEN-1:0] q_a, q_b, q_c;
    logic [NUM_GPR-1:0] gpr_valid_reg;
    logic               fwd_valid_reg;
    logic [REG_IDX_W-1:0] fwd_idx_reg;
    logic [XLEN-1:0]      fwd_data_reg;

    logic [3:0] flags_reg, flags_next;
    logic       out_valid_reg;
    logic [74:0] out_reg, out_next;

    logic [XLEN-1:0] mask, a, b, c, bsh, bl, product, lhs, rhs, rhs_eff, res, logic_res;
    logic [XLEN:0]   ext;
    logic [63:0]     mulx;
    logic [31:0]     mul_x, mul_y;
    logic            sub, cy, ov, sl, sr, sres, top_n;
    logic            e_done, out_free, wr_en;
    logic [REG_IDX_W-1:0] wr_idx;
    logic [XLEN-1:0] wr_data, final_res;
    logic            ill;

    function automatic logic [XLEN-1:0] rd_gpr(input logic [REG_IDX_W-1:0] idx,
                                               input logic [XLEN-1:0] qv,
                                               input logic fv,
                                               input logic [REG_IDX_W-1:0] fi,
                                               input logic [XLEN-1:0] fd,
                                               input logic [NUM_GPR-1:0] vb);
        logic [XLEN-1:0] r;
        r = '0;
        if (idx != ZERO_REG) begin
            if (fv && fi == idx) begin
                r = fd;
            end else if (vb[idx]) begin
                r = qv;
            end
        end
        return r;
    endfunction

    function automatic logic [XLEN-1:0] barrel_shift(input logic [XLEN-1:0] v,
                                                     input logic [1:0] st,
                                                     input logic [5:0] amt,
                                                     input logic sf);
        logic [2*XLEN-1:0] dbl;
        logic [63:0]       dbl32;
        logic [31:0]       v32;
        logic [XLEN-1:0]   r;
        dbl   = {v, v};
        v32   = v[31:0];
        dbl32 = {v32, v32};
        r     = v;
        if (amt != 6'd0) begin
            if (sf) begin
                unique case (st)
                    SHIFT_LSL: r = v << amt;
                    SHIFT_LSR: r = v >> amt;
                    SHIFT_ASR: r = $unsigned($signed(v) >>> amt);
                    default:   r = 64'(dbl >> amt);
                endcase
            end else begin
                unique case (st)
                    SHIFT_LSL: r = {32'd0, v32 << amt[4:0]};
                    SHIFT_LSR: r = {32'd0, v32 >> amt[4:0]};
                    SHIFT_ASR: r = {32'd0, $unsigned($signed(v32) >>> amt[4:0])};
                    default:   r = {32'd0, 32'(dbl32 >> amt[4:0])};
                endcase
            end
        end
        return r;
    endfunction

    // register file: three copies, one read port each
    assign rd_sel = q_pop ? q_head : e_reg;

    ralu_ram #(.WIDTH(XLEN), .DEPTH(NUM_GPR)) u_ram_a (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_idx), .wr_data(wr_data),
        .rd_addr(rd_sel.rn), .rd_data(q_a));
    ralu_ram #(.WIDTH(XLEN), .DEPTH(NUM_GPR)) u_ram_b (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_idx), .wr_data(wr_data),
        .rd_addr(rd_sel.rm), .rd_data(q_b));
    ralu_ram #(.WIDTH(XLEN), .DEPTH(NUM_GPR)) u_ram_c (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_idx), .wr_data(wr_data),
        .rd_addr(rd_sel.ra), .rd_data(q_c));

    assign mask = e_reg.sf ? {XLEN{1'b1}} : {32'd0, 32'hFFFF_FFFF};
    assign a = rd_gpr(e_reg.rn, q_a, fwd_valid_reg, fwd_idx_reg, fwd_data_reg, gpr_valid_reg) & mask;
    assign b = rd_gpr(e_reg.rm, q_b, fwd_valid_reg, fwd_idx_reg, fwd_data_reg, gpr_valid_reg) & mask;
    assign c = rd_gpr(e_reg.ra, q_c, fwd_valid_reg, fwd_idx_reg, fwd_data_reg, gpr_valid_reg) & mask;

    // shared 32x32 multiplier, one partial product in each of the LL, LH and HL steps
    always_comb begin
        unique case (mul_cnt_reg)
            MUL_STEP_LL: begin mul_x = a[31:0];  mul_y = b[31:0];  end
            MUL_STEP_LH: begin mul_x = a[31:0];  mul_y = b[63:32]; end
            MUL_STEP_HL: begin mul_x = a[63:32]; mul_y = b[31:0];  end
            default:     begin mul_x = '0;       mul_y = '0;       end
        endcase
    end
    assign mulx    = mul_x * mul_y;
    assign product = (p0_reg + {p1_reg + p2_reg, 32'd0}) & mask;

    assign bsh = barrel_shift(b, e_reg.stype, e_reg.amt, e_reg.sf);
    assign bl  = e_reg.neg ? (~bsh & mask) : bsh;

    assign lhs     = (e_reg.kind == KIND_MUL) ? c : a;
    assign rhs     = (e_reg.kind == KIND_MUL) ? product : bsh;
    assign sub     = (e_reg.kind == KIND_MUL) ? e_reg.mul_sub : e_reg.opc[1];
    assign rhs_eff = (sub ? ~rhs : rhs) & mask;
    assign ext     = {1'b0, lhs} + {1'b0, rhs_eff} + {{XLEN{1'b0}}, sub};
    assign cy      = e_reg.sf ? ext[XLEN] : ext[32];
    assign res     = ext[XLEN-1:0] & mask;
    assign sl      = e_reg.sf ? lhs[63] : lhs[31];
    assign sr      = e_reg.sf ? rhs[63] : rhs[31];
    assign sres    = e_reg.sf ? res[63] : res[31];
    assign ov      = sub ? ((sl != sr) && (sres != sl)) : ((sl == sr) && (sres != sl));

    always_comb begin
        unique case (e_reg.opc)
            LOGIC_ORR: logic_res = a | bl;
            LOGIC_EOR: logic_res = a ^ bl;
            default:   logic_res = a & bl;
        endcase
    end

    assign out_free = !out_valid_reg || m_tready;
    assign e_done   = e_valid_reg && out_free &&
                      ((e_reg.kind != KIND_MUL) || (mul_cnt_reg == MUL_STEP_SUM));
    assign q_pop    = !e_valid_reg || e_done;

    always_comb begin
        flags_next = flags_reg;
        final_res  = '0;
        ill        = 1'b0;
        top_n      = 1'b0;
        unique case (e_reg.kind)
            KIND_LOAD:  final_res = e_reg.load_value;
            KIND_MUL:   final_res = res;
            KIND_ARITH: begin
                final_res = res;
                if (e_reg.opc[0]) begin
                    flags_next = {sres, res == '0, cy, ov};
                end
            end
            KIND_LOGIC: begin
                final_res = logic_res;
                if (e_reg.opc == LOGIC_ANDS) begin
                    top_n      = e_reg.sf ? logic_res[63] : logic_res[31];
                    flags_next = {top_n, logic_res == '0, 2'b00};
                end
            end
            default:    ill = 1'b1;
        endcase
        if (!(e_valid_reg && e_done)) begin
            flags_next = flags_reg;
        end
    end

    assign wr_idx  = e_reg.rd;
    assign wr_data = final_res;
    assign wr_en   = e_done && !ill && (e_reg.rd != ZERO_REG);

    always_comb begin
        out_next = out_reg;
        if (e_done) begin
            out_next = {ill, flags_next[0], flags_next[1], flags_next[2], flags_next[3],
                        final_res, ill ? {REG_IDX_W{1'b0}} : e_reg.rd, wr_en};
        end
    end

    always_comb begin
        e_next       = e_reg;
        e_valid_next = e_valid_reg;
        mul_cnt_next = mul_cnt_reg;
        if (e_valid_reg && e_reg.kind == KIND_MUL && mul_cnt_reg != MUL_STEP_SUM) begin
            mul_cnt_next = mul_cnt_reg + 2'd1;
        end
        if (q_pop) begin
            e_next       = q_head;
            e_valid_next = q_not_empty;
            mul_cnt_next = MUL_STEP_LL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg   <= 1'b0;
            mul_cnt_reg   <= MUL_STEP_LL;
            gpr_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            e_valid_reg <= e_valid_next;
            mul_cnt_reg <= mul_cnt_next;
            flags_reg   <= flags_next;
            if (wr_en) begin
                gpr_valid_reg[wr_idx] <= 1'b1;
                fwd_valid_reg         <= 1'b1;
            end
            if (e_done) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        e_reg   <= e_next;
        out_reg <= out_next;
        if (wr_en) begin
            fwd_idx_reg  <= wr_idx;
            fwd_data_reg <= wr_data;
        end
        unique case (mul_cnt_reg)
            MUL_STEP_LL: p0_reg <= mulx;
            MUL_STEP_LH: p1_reg <= mulx[31:0];
            MUL_STEP_HL: p2_reg <= mulx[31:0];
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg};

    a_no_zero_reg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> wr_idx != ZERO_REG)
        else $error("write to zero register");
    a_mul_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_cnt_reg != MUL_STEP_LL) |-> (e_valid_reg && e_reg.kind == KIND_MUL))
        else $error("multiply step without multiply");
    a_illegal_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_done && ill) |=> (flags_reg == $past(flags_reg)))
        else $error("illegal item changed flags");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !e_done)
        else $error("result overwritten while stalled");
endmodule

// File: hdl/arm64_register_alu_execute.sv
// A64 register-form ALU execute block: front decode, queue, back execute.
// Items pass the queue entry, execute register and output register; multiply-add/sub
// takes four steps (LL, LH, HL, SUM) with one 32x32 multiplier. Throughput: one item
// per cycle unless the output stalls; a multiply item holds the back end for its steps.
// Synchronous active-low reset clears registers (via valid bits), flags, queue.
// Depends on ralu_pkg, ralu_front, ralu_queue, ralu_back, ralu_ram.
module arm64_register_alu_execute (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // instr_word[31:0], load_index[36:32], load_value[100:37]
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata    // write_enable[0], dest_index[5:1], result_value[69:6],
                                    // flag_n[70], flag_z[71], flag_c[72], flag_v[73], illegal[74]
);
    import ralu_pkg::*;

    decoded_t push_entry, q_head;
    logic     push, q_full, q_not_empty, q_pop;

    ralu_front u_front (
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .queue_full(q_full), .push(push), .push_entry(push_entry));

    ralu_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_entry(push_entry),
        .pop(q_pop), .full(q_full), .not_empty(q_not_empty), .head(q_head));

    ralu_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_not_empty(q_not_empty), .q_head(q_head),
        .q_pop(q_pop), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
endmodule

// File: tb/sv/arm64_register_alu_execute_tb.sv
// Testbench for arm64_register_alu_execute: directed and random A64 register-form
// items, predicted by a scoreboard class holding its own register file and NZCV.
// Depends on ralu_pkg and the block itself.
`timescale 1ns / 100ps

module arm64_register_alu_execute_tb;
    import ralu_pkg::*;

    typedef struct packed {
        logic        illegal;
        logic [3:0]  nzcv;
        logic [63:0] value;
        logic [4:0]  dest;
        logic        we;
    } alu_result_t;

    int unsigned error_count = 0;

    task automatic report(input string what, input logic [79:0] got, input logic [79:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    class alu_scoreboard;
        logic [63:0] gpr[NUM_GPR];
        logic [3:0]  nzcv;
        alu_result_t pending[$];

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            nzcv = '0;
        endfunction

        function logic [63:0] rd_reg(logic [4:0] idx);
            return (idx == ZERO_REG) ? 64'd0 : gpr[idx];
        endfunction

        function logic [63:0] shifted(logic [63:0] v, logic [1:0] st, int amt, bit sf);
            logic [63:0] mask, r;
            int w;
            mask = sf ? '1 : 64'hFFFF_FFFF;
            w = sf ? 64 : 32;
            if (amt == 0) return v;
            case (st)
                SHIFT_LSL: r = v << amt;
                SHIFT_LSR: r = v >> amt;
                SHIFT_ASR: begin
                    r = v >> amt;
                    if (v[w-1]) r |= mask & ~(mask >> amt);
                end
                default: r = (v >> amt) | (v << (w - amt));
            endcase
            return r & mask;
        endfunction

        function void put_nz(logic [63:0] r, bit sf, bit c, bit v);
            nzcv = {sf ? r[63] : r[31], r == 0, c, v};
        endfunction

        function logic [63:0] addsub(logic [63:0] l, logic [63:0] rr, bit sub, bit setf, bit sf);
            logic [63:0] mask, r;
            logic [64:0] sum;
            int t;
            bit c, v;
            mask = sf ? '1 : 64'hFFFF_FFFF;
            t = sf ? 63 : 31;
            r = (sub ? l - rr : l + rr) & mask;
            if (setf) begin
                sum = {1'b0, l} + {1'b0, rr};
                if (sub) begin
                    c = l >= rr;
                    v = (l[t] != rr[t]) && (r[t] != l[t]);
                end else begin
                    c = sf ? sum[64] : (sum > 65'hFFFF_FFFF);
                    v = (l[t] == rr[t]) && (r[t] != l[t]);
                end
                put_nz(r, sf, c, v);
            end
            return r;
        endfunction

        function void note_input(bit func, logic [31:0] w, logic [4:0] li, logic [63:0] lv);
            alu_result_t e;
            logic [63:0] mask, a, b, res;
            bit sf, ill;
            int amt;
            e = '0;
            if (func) begin
                e.dest = li;
                e.value = lv;
                if (li != ZERO_REG) begin
                    gpr[li] = lv;
                    e.we = 1;
                end
            end else begin
                sf = w[31];
                mask = sf ? '1 : 64'hFFFF_FFFF;
                amt = int'(w[15:10]);
                a = rd_reg(w[9:5]) & mask;
                b = rd_reg(w[20:16]) & mask;
                res = '0;
                ill = 0;
                if (w[27:25] != MAJOR_DP_REG) ill = 1;
                else if (w[28]) begin
                    if (w[24:21] != MUL_OP31) ill = 1;
                    else res = addsub(rd_reg(w[14:10]) & mask, (a * b) & mask, w[15], 0, sf);
                end else if (!sf && amt >= 32) ill = 1;
                else if (w[24] && (w[21] || (w[23:22] == SHIFT_ROR && amt != 0))) ill = 1;
                else begin
                    b = shifted(b, w[23:22], amt, sf);
                    if (w[24]) res = addsub(a, b, w[30], w[29], sf);
                    else begin
                        if (w[21]) b = ~b & mask;
                        case (w[30:29])
                            LOGIC_AND: res = a & b;
                            LOGIC_ORR: res = a | b;
                            LOGIC_EOR: res = a ^ b;
                            default: begin
                                res = a & b;
                                put_nz(res, sf, 0, 0);
                            end
                        endcase
                    end
                end
                e.illegal = ill;
                if (!ill) begin
                    e.value = res & mask;
                    e.dest = w[4:0];
                    if (w[4:0] != ZERO_REG) begin
                        gpr[w[4:0]] = e.value;
                        e.we = 1;
                    end
                end
            end
            e.nzcv = nzcv;
            pending.push_back(e);
        endfunction

        task check_result(logic [79:0] d);
            alu_result_t e;
            if (pending.size() == 0) begin
                report("unexpected result", d, '0);
                return;
            end
            e = pending.pop_front();
            if (d[0] !== e.we) report("write_enable", d[0], e.we);
            if (d[5:1] !== e.dest) report("dest_index", d[5:1], e.dest);
            if (d[69:6] !== e.value) report("result_value", d[69:6], e.value);
            if (d[70] !== e.nzcv[3]) report("flag_n", d[70], e.nzcv[3]);
            if (d[71] !== e.nzcv[2]) report("flag_z", d[71], e.nzcv[2]);
            if (d[72] !== e.nzcv[1]) report("flag_c", d[72], e.nzcv[1]);
            if (d[73] !== e.nzcv[0]) report("flag_v", d[73], e.nzcv[0]);
            if (d[74] !== e.illegal) report("illegal", d[74], e.illegal);
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [79:0]  m_tdata;

    arm64_register_alu_execute dut (.*);

    alu_scoreboard sb = new();
    longint unsigned cycles = 0;
    bit  hold_off = 0;

    initial forever #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // receiver stall pattern plus one long hold-off
    initial begin
        int mode;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            mode = int'((cycles / 300) % 3);
            if (hold_off) m_tready <= 0;
            else if (mode == 0) m_tready <= 1;
            else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
            else m_tready <= ($urandom_range(0, 1) == 1);
        end
    end

    initial begin
        wait (cycles > 1200);
        hold_off = 1;
        repeat (150) @(posedge aclk);
        hold_off = 0;
    end

    task automatic send(bit func, logic [31:0] w, logic [4:0] li, logic [63:0] lv);
        @(negedge aclk);
        s_tvalid <= 1;
        s_tuser <= func;
        s_tdata <= {3'b0, lv, li, w};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(func, w, li, lv);
    endtask

    task automatic pause();
        @(negedge aclk);
        s_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = 64'h8000_0000_0000_0000;
            3: v = 64'h0000_0000_FFFF_FFFF;
            4: v = 64'h0000_0000_8000_0000;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        int k;
        w = $urandom;
        k = $urandom_range(0, 9);
        if (k < 8) w[27:25] = MAJOR_DP_REG;
        if (k < 3) begin
            w[28] = 1;
            w[24:21] = MUL_OP31;
        end else if (k < 8) begin
            w[28] = 0;
            if (w[24] && $urandom_range(0, 3) != 0) w[21] = 0;
            if (!w[31] && $urandom_range(0, 3) != 0) w[15] = 0;
            if ($urandom_range(0, 3) == 0) w[15:10] = 0;
        end
        return w;
    endfunction

    initial begin
        int n, burst;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // directed: loads of extremes, then add/sub, logical and multiply operations and each illegal case
        send(1, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        send(1, 0, 1, 64'h8000_0000_0000_0000);
        send(1, 0, 2, 64'h0000_0000_7FFF_FFFF);
        send(1, 0, 30, 64'h1);
        send(1, 0, 31, 64'hDEAD_BEEF_0123_4567);
        send(0, 32'h8B01_0003, 0, 0);       // add x3,x0,x1
        send(0, 32'hAB00_0004, 0, 0);       // adds x4,x0,x0
        send(0, 32'hEB01_0025, 0, 0);       // subs x5,x1,x1
        send(0, 32'h2B02_0046, 0, 0);       // adds w6,w2,w2
        send(0, 32'h6B1F_03E7, 0, 0);       // subs w7,wzr,wzr
        send(0, 32'h8A01_001F, 0, 0);       // and xzr
        send(0, 32'hAA20_0028, 0, 0);       // orn
        send(0, 32'hCA81_FC09, 0, 0);       // eor asr 63
        send(0, 32'hEAC1_000A, 0, 0);       // ands ror 0
        send(0, 32'h0AC2_7C4B, 0, 0);       // and w ror 31
        send(0, 32'h9B01_780C, 0, 0);       // madd
        send(0, 32'hFB01_F80D, 0, 0);       // msub with opc bits
        send(0, 32'h8A01_0000 & 32'hF1FF_FFFF, 0, 0); // wrong major
        send(0, 32'h9B41_000E, 0, 0);       // bad mul opcode
        send(0, 32'h8B21_000F, 0, 0);       // arith with N
        send(0, 32'h8BC1_0410, 0, 0);       // arith ror nonzero
        send(0, 32'h0B01_8011, 0, 0);       // 32-bit amount 32
        send(0, 32'h8B41_FC12, 0, 0);       // lsr 63
        n = 0;
        while (n < 1950) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                if ($urandom_range(0, 4) == 0)
                    send(1, $urandom, 5'($urandom_range(0, 31)), rand64());
                else
                    send(0, rand_instr(), 5'($urandom), {$urandom, $urandom});
                n++;
            end
            if ($urandom_range(0, 2) != 0) pause();
        end
        @(negedge aclk);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
